[rtl/core/looping_sample_voice_mixer_top_defines.svh]
// Assertion macros shared by the sample player RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef LOOPING_SAMPLE_VOICE_MIXER_TOP_DEFINES_SVH
`define LOOPING_SAMPLE_VOICE_MIXER_TOP_DEFINES_SVH

// This macro checks a property that holds at every clock edge.
`define SLMX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// This macro checks that the consequent holds in the cycle after the antecedent.
`define SLMX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/slmx_pkg.sv]
// Shared types and constants for the looping sample voice mixer.
// This package has no dependencies and is used by every RTL file in the block.
package slmx_pkg;

    localparam int DATA_W    = 16;
    localparam int LEN_W     = 17;
    localparam int SLOT_FW   = 6;
    localparam int ADDR_FW   = 16;
    localparam int ALU_W     = 18;
    localparam int MASK_FW   = 2;
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_TRIGGER = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_TRIG_RD,
        S_TRIG,
        S_WRITE,
        S_VOICE,
        S_VDESC,
        S_RED,
        S_VREAD,
        S_VACC,
        S_VCMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               valid;
        logic               loop_en;
        logic [ADDR_FW-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [ADDR_FW-1:0] loop_pt;
    } desc_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             ge;
    } alu_rsp_t;

endpackage

[rtl/core/looping_sample_voice_mixer_top.sv]
// Top level of the looping sample voice mixer: stream ports, sequencer and voice state.
// Depends on slmx_pkg, slmx_alu, slmx_desc_ram, slmx_sample_ram and the assertion header.
//
// Each input transaction is one command: write a sample word, load a descriptor, trigger
// a voice, or tick. A tick returns one output transaction holding the wrapping 16-bit sum
// of the words read from all active voices and a mask of those voices; other commands
// return nothing. The block works on one command at a time and holds s_tready low until
// it is done. An address is folded into MEM_WORDS by R compare-and-subtract steps
// (R = 2 for 65536 words, 0 at or above 262144 words), which a write runs before it
// stores its word. A tick reads each playing voice's descriptor, forms and folds the
// address, reads the word, adds it to the sum and steps the position; it passes over a
// silent voice. All arithmetic shares the single adder and subtractor, and the sample
// memory has a single read port. The output register lets the next command be accepted
// while a tick result waits to be taken. The descriptor table reads as all invalid right
// after reset with no clearing pass.
`include "looping_sample_voice_mixer_top_defines.svh"

module looping_sample_voice_mixer_top #(
    parameter int VOICES    = 2,
    parameter int SLOTS     = 64,
    parameter int MEM_WORDS = 65536
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_index[5:0], voice[6], address[22:7], word_data[38:23], length[55:39],
    // loop_point[71:56], loop_enable[72], desc_valid[73], zero padding[79:74]
    input  logic [slmx_pkg::S_TDATA_W-1:0]     s_tdata,
    // cmd[1:0]
    input  logic [slmx_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // mix[15:0], active_mask[17:16], zero padding[23:18]
    output logic [slmx_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int VOICE_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int AW_ALU    = slmx_pkg::ALU_W;
    localparam int DW        = slmx_pkg::DATA_W;
    localparam int LW        = slmx_pkg::LEN_W;
    localparam int Q_MAX     = ((1 << AW_ALU) - 1) / MEM_WORDS;
    localparam int RED_STEPS = $clog2(Q_MAX + 1);
    localparam int RED_CW    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam bit HAS_RED   = (RED_STEPS > 0);
    localparam int RED_INIT  = HAS_RED ? (RED_STEPS - 1) : 0;
    localparam logic [31:0] MEM_WORDS_U = 32'(MEM_WORDS);

    slmx_pkg::state_t state_reg, state_next;

    // Latched command payload.
    slmx_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [slmx_pkg::SLOT_FW-1:0]   slot_reg, slot_next;
    logic                           voice_reg, voice_next;
    logic [slmx_pkg::ADDR_FW-1:0]   addr_reg, addr_next;
    logic [DW-1:0]                  word_reg, word_next;
    logic [LW-1:0]                  len_reg, len_next;
    logic [slmx_pkg::ADDR_FW-1:0]   lp_reg, lp_next;
    logic                           lpen_reg, lpen_next;
    logic                           dval_reg, dval_next;

    // Voice state.
    logic [VOICES-1:0]              vact_reg, vact_next;
    logic [LW-1:0]                  vpos_reg [VOICES];
    logic [LW-1:0]                  vpos_next [VOICES];
    logic [slmx_pkg::SLOT_FW-1:0]   vdesc_reg [VOICES];
    logic [slmx_pkg::SLOT_FW-1:0]   vdesc_next [VOICES];

    // Tick and address working registers.
    logic [VOICE_W-1:0]             vidx_reg, vidx_next;
    logic [RED_CW-1:0]              red_cnt_reg, red_cnt_next;
    logic [AW_ALU-1:0]              rem_reg, rem_next;
    logic [AW_ALU-1:0]              nxt_reg, nxt_next;
    logic [DW-1:0]                  sum_reg, sum_next;
    logic [VOICES-1:0]              mask_reg, mask_next;
    slmx_pkg::desc_t                cur_reg, cur_next;

    // Output register.
    logic                           m_valid_reg, m_valid_next;
    logic [DW-1:0]                  mix_reg, mix_next;
    logic [slmx_pkg::MASK_FW-1:0]   amask_reg, amask_next;

    slmx_pkg::cmd_t                 s_cmd;
    logic                           s_accept;
    logic                           slot_ok, voice_ok, cur_slot_ok, last_voice, out_free;
    logic [slmx_pkg::SLOT_FW-1:0]   cur_slot;
    logic [VOICE_W-1:0]             trig_v;
    logic [VOICES+1:0]              mask_ext;
    logic [AW_ALU-1:0]              red_div;

    slmx_pkg::alu_req_t             alu_req;
    slmx_pkg::alu_rsp_t             alu_rsp;
    logic                           desc_wr_en, desc_rd_en;
    logic [SLOT_W-1:0]              desc_rd_idx;
    slmx_pkg::desc_t                desc_wr_data, desc_q;
    logic                           smp_wr_en, smp_rd_en;
    logic [DW-1:0]                  smp_rd_data;

    assign s_cmd       = slmx_pkg::cmd_t'(s_tuser);
    assign s_accept    = s_tvalid && s_tready;
    assign slot_ok     = 32'(slot_reg) < 32'(SLOTS);
    assign voice_ok    = 32'(voice_reg) < 32'(VOICES);
    assign trig_v      = VOICE_W'(voice_reg);
    assign cur_slot    = vdesc_reg[vidx_reg];
    assign cur_slot_ok = 32'(cur_slot) < 32'(SLOTS);
    assign last_voice  = vidx_reg == VOICE_W'(VOICES - 1);
    assign out_free    = !m_valid_reg || m_tready;
    assign mask_ext    = {2'b00, mask_reg};
    assign red_div     = AW_ALU'(MEM_WORDS_U << red_cnt_reg);

    slmx_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    slmx_desc_ram #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_desc_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (desc_wr_en),
        .wr_idx  (SLOT_W'(slot_reg)),
        .wr_data (desc_wr_data),
        .rd_en   (desc_rd_en),
        .rd_idx  (desc_rd_idx),
        .rd_data (desc_q)
    );

    slmx_sample_ram #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (MEM_AW)
    ) u_sample_ram (
        .aclk    (aclk),
        .wr_en   (smp_wr_en),
        .wr_addr (MEM_AW'(rem_reg)),
        .wr_data (word_reg),
        .rd_en   (smp_rd_en),
        .rd_addr (MEM_AW'(rem_reg)),
        .rd_data (smp_rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            slmx_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    case (s_cmd)
                        slmx_pkg::CMD_WRITE: begin
                            state_next = HAS_RED ? slmx_pkg::S_RED : slmx_pkg::S_WRITE;
                        end
                        slmx_pkg::CMD_LOAD:    state_next = slmx_pkg::S_LOAD;
                        slmx_pkg::CMD_TRIGGER: state_next = slmx_pkg::S_TRIG_RD;
                        default:               state_next = slmx_pkg::S_VOICE;
                    endcase
                end
            end
            slmx_pkg::S_LOAD:    state_next = slmx_pkg::S_IDLE;
            slmx_pkg::S_TRIG_RD: state_next = slmx_pkg::S_TRIG;
            slmx_pkg::S_TRIG:    state_next = slmx_pkg::S_IDLE;
            slmx_pkg::S_WRITE:   state_next = slmx_pkg::S_IDLE;
            slmx_pkg::S_VOICE: begin
                if (vact_reg[vidx_reg] && cur_slot_ok) begin
                    state_next = slmx_pkg::S_VDESC;
                end else if (last_voice) begin
                    state_next = slmx_pkg::S_DONE;
                end
            end
            slmx_pkg::S_VDESC: begin
                state_next = HAS_RED ? slmx_pkg::S_RED : slmx_pkg::S_VREAD;
            end
            slmx_pkg::S_RED: begin
                if (red_cnt_reg == '0) begin
                    state_next = (cmd_reg == slmx_pkg::CMD_WRITE) ? slmx_pkg::S_WRITE
                                                                  : slmx_pkg::S_VREAD;
                end
            end
            slmx_pkg::S_VREAD: state_next = slmx_pkg::S_VACC;
            slmx_pkg::S_VACC:  state_next = slmx_pkg::S_VCMP;
            slmx_pkg::S_VCMP: begin
                state_next = last_voice ? slmx_pkg::S_DONE : slmx_pkg::S_VOICE;
            end
            slmx_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = slmx_pkg::S_IDLE;
                end
            end
            default: state_next = slmx_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        alu_req.op   = slmx_pkg::ALU_ADD;
        alu_req.a    = '0;
        alu_req.b    = '0;
        desc_wr_en   = 1'b0;
        desc_wr_data = {dval_reg, lpen_reg, addr_reg, len_reg, lp_reg};
        desc_rd_en   = 1'b0;
        desc_rd_idx  = SLOT_W'(slot_reg);
        smp_wr_en    = 1'b0;
        smp_rd_en    = 1'b0;
        case (state_reg)
            slmx_pkg::S_IDLE:    s_tready = 1'b1;
            slmx_pkg::S_LOAD:    desc_wr_en = slot_ok;
            slmx_pkg::S_TRIG_RD: desc_rd_en = 1'b1;
            slmx_pkg::S_WRITE:   smp_wr_en = 1'b1;
            slmx_pkg::S_VOICE: begin
                desc_rd_en  = 1'b1;
                desc_rd_idx = SLOT_W'(cur_slot);
            end
            slmx_pkg::S_VDESC: begin
                alu_req.a = AW_ALU'(desc_q.start);
                alu_req.b = AW_ALU'(vpos_reg[vidx_reg]);
            end
            slmx_pkg::S_RED: begin
                alu_req.op = slmx_pkg::ALU_SUB;
                alu_req.a  = rem_reg;
                alu_req.b  = red_div;
            end
            slmx_pkg::S_VREAD: begin
                smp_rd_en = 1'b1;
                alu_req.a = AW_ALU'(vpos_reg[vidx_reg]);
                alu_req.b = AW_ALU'(1);
            end
            slmx_pkg::S_VACC: begin
                alu_req.a = AW_ALU'(sum_reg);
                alu_req.b = AW_ALU'(smp_rd_data);
            end
            slmx_pkg::S_VCMP: begin
                alu_req.op = slmx_pkg::ALU_SUB;
                alu_req.a  = nxt_reg;
                alu_req.b  = AW_ALU'(cur_reg.length);
            end
            default: s_tready = 1'b0;
        endcase
    end

    always_comb begin
        cmd_next     = cmd_reg;
        slot_next    = slot_reg;
        voice_next   = voice_reg;
        addr_next    = addr_reg;
        word_next    = word_reg;
        len_next     = len_reg;
        lp_next      = lp_reg;
        lpen_next    = lpen_reg;
        dval_next    = dval_reg;
        vact_next    = vact_reg;
        vpos_next    = vpos_reg;
        vdesc_next   = vdesc_reg;
        vidx_next    = vidx_reg;
        red_cnt_next = red_cnt_reg;
        rem_next     = rem_reg;
        nxt_next     = nxt_reg;
        sum_next     = sum_reg;
        mask_next    = mask_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg && !m_tready;
        mix_next     = mix_reg;
        amask_next   = amask_reg;
        case (state_reg)
            slmx_pkg::S_IDLE: begin
                if (s_accept) begin
                    cmd_next     = s_cmd;
                    slot_next    = s_tdata[5:0];
                    voice_next   = s_tdata[6];
                    addr_next    = s_tdata[22:7];
                    word_next    = s_tdata[38:23];
                    len_next     = s_tdata[55:39];
                    lp_next      = s_tdata[71:56];
                    lpen_next    = s_tdata[72];
                    dval_next    = s_tdata[73];
                    rem_next     = AW_ALU'(s_tdata[22:7]);
                    red_cnt_next = RED_CW'(RED_INIT);
                    vidx_next    = '0;
                    sum_next     = '0;
                    mask_next    = '0;
                end
            end
            slmx_pkg::S_TRIG: begin
                if (voice_ok) begin
                    vpos_next[trig_v]  = '0;
                    vdesc_next[trig_v] = slot_reg;
                    vact_next[trig_v]  = slot_ok && desc_q.valid && (desc_q.length != '0);
                end
            end
            slmx_pkg::S_VOICE: begin
                if (vact_reg[vidx_reg]) begin
                    mask_next[vidx_reg] = 1'b1;
                    if (!cur_slot_ok) begin
                        vact_next[vidx_reg] = 1'b0;
                    end
                end
                if (!(vact_reg[vidx_reg] && cur_slot_ok) && !last_voice) begin
                    vidx_next = vidx_reg + VOICE_W'(1);
                end
            end
            slmx_pkg::S_VDESC: begin
                cur_next     = desc_q;
                rem_next     = alu_rsp.res;
                red_cnt_next = RED_CW'(RED_INIT);
            end
            slmx_pkg::S_RED: begin
                if (alu_rsp.ge) begin
                    rem_next = alu_rsp.res;
                end
                if (red_cnt_reg != '0) begin
                    red_cnt_next = red_cnt_reg - RED_CW'(1);
                end
            end
            slmx_pkg::S_VREAD: nxt_next = alu_rsp.res;
            slmx_pkg::S_VACC:  sum_next = alu_rsp.res[DW-1:0];
            slmx_pkg::S_VCMP: begin
                vpos_next[vidx_reg] = nxt_reg[LW-1:0];
                if (alu_rsp.ge) begin
                    if (cur_reg.loop_en) begin
                        vpos_next[vidx_reg] = LW'(cur_reg.loop_pt);
                    end else begin
                        vact_next[vidx_reg] = 1'b0;
                    end
                end
                if (!last_voice) begin
                    vidx_next = vidx_reg + VOICE_W'(1);
                end
            end
            slmx_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    mix_next     = sum_reg;
                    amask_next   = mask_ext[1:0];
                end
            end
            default: m_valid_next = m_valid_reg && !m_tready;
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        slot_reg  <= slot_next;
        voice_reg <= voice_next;
        addr_reg  <= addr_next;
        word_reg  <= word_next;
        len_reg   <= len_next;
        lp_reg    <= lp_next;
        lpen_reg  <= lpen_next;
        dval_reg  <= dval_next;
        rem_reg   <= rem_next;
        nxt_reg   <= nxt_next;
        sum_reg   <= sum_next;
        mask_reg  <= mask_next;
        cur_reg   <= cur_next;
        mix_reg   <= mix_next;
        amask_reg <= amask_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slmx_pkg::S_IDLE;
            vact_reg    <= '0;
            vpos_reg    <= '{default: '0};
            vdesc_reg   <= '{default: '0};
            vidx_reg    <= '0;
            red_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vact_reg    <= vact_next;
            vpos_reg    <= vpos_next;
            vdesc_reg   <= vdesc_next;
            vidx_reg    <= vidx_next;
            red_cnt_reg <= red_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, amask_reg, mix_reg};

    `SLMX_ASSERT(a_addr_folded, (state_reg == slmx_pkg::S_WRITE || state_reg == slmx_pkg::S_VREAD) |-> (32'(rem_reg) < MEM_WORDS_U), "memory address not folded below MEM_WORDS")
    `SLMX_ASSERT_NEXT(a_tick_start, s_accept && (s_cmd == slmx_pkg::CMD_TICK), state_reg == slmx_pkg::S_VOICE && vidx_reg == '0 && sum_reg == '0 && mask_reg == '0, "tick did not start from a clear accumulator")
    `SLMX_ASSERT_NEXT(a_no_spurious_result, s_accept && (s_cmd != slmx_pkg::CMD_TICK) && !m_tvalid, !m_tvalid, "non-tick transaction produced a result")

endmodule

[rtl/core/slmx_alu.sv]
// Shared adder and subtractor of the sample player sequencer.
// Depends on slmx_pkg for the request and response structs.
module slmx_alu (
    input  slmx_pkg::alu_req_t req,
    output slmx_pkg::alu_rsp_t rsp
);

    logic [slmx_pkg::ALU_W:0] full;

    always_comb begin
        if (req.op == slmx_pkg::ALU_SUB) begin
            full = {1'b0, req.a} - {1'b0, req.b};
        end else begin
            full = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.res = full[slmx_pkg::ALU_W-1:0];
        rsp.ge  = ~full[slmx_pkg::ALU_W];
    end

endmodule

[rtl/core/slmx_desc_ram.sv]
// Descriptor table with one write port, one registered read port and per-slot valid bits.
// Depends on slmx_pkg for the descriptor struct.
module slmx_desc_ram #(
    parameter int SLOTS  = 64,
    parameter int SLOT_W = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [SLOT_W-1:0]   wr_idx,
    input  slmx_pkg::desc_t     wr_data,
    input  logic                rd_en,
    input  logic [SLOT_W-1:0]   rd_idx,
    output slmx_pkg::desc_t     rd_data
);

    slmx_pkg::desc_t mem [SLOTS];
    logic [SLOTS-1:0] written_reg;
    logic             hit_reg;
    slmx_pkg::desc_t  rd_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_idx] <= 1'b1;
            end
            if (rd_en) begin
                hit_reg <= written_reg[rd_idx];
            end
        end
    end

    // A slot that was never loaded reads as an all-zero, invalid descriptor.
    assign rd_data = hit_reg ? rd_q_reg : '0;

endmodule

[rtl/core/slmx_sample_ram.sv]
// Sample word memory with one write port and one registered read port.
// Depends on slmx_pkg for the data width.
module slmx_sample_ram #(
    parameter int MEM_WORDS = 65536,
    parameter int AW        = 16
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic [slmx_pkg::DATA_W-1:0]      wr_data,
    input  logic                             rd_en,
    input  logic [AW-1:0]                    rd_addr,
    output logic [slmx_pkg::DATA_W-1:0]      rd_data
);

    logic [slmx_pkg::DATA_W-1:0] mem [MEM_WORDS];
    logic [slmx_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for looping_sample_voice_mixer_top: a tracker class predicts every
// tick's mix and voice mask, and plain tasks drive commands under random stream stalls.
// Depends on slmx_pkg and the looping_sample_voice_mixer_top RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int LIMIT = 500000;

    typedef struct packed {
        logic [5:0]  pad;
        logic        desc_valid;
        logic        loop_enable;
        logic [15:0] loop_point;
        logic [16:0] length;
        logic [15:0] word_data;
        logic [15:0] address;
        logic        voice;
        logic [5:0]  sample_index;
    } cmd_fields_t;

    typedef struct packed {
        logic [1:0]  active_mask;
        logic [15:0] mix;
    } mix_result_t;

    class mix_tracker;
        slmx_pkg::desc_t slot_table [64];
        bit [15:0]       mem [65536];
        bit              written [65536];
        bit              playing [2];
        logic [16:0]     play_pos [2];
        logic [5:0]      play_slot [2];
        mix_result_t     pending_mixes [$];
        int              errors;

        function new();
            foreach (slot_table[i]) slot_table[i] = '0;
            foreach (playing[i]) begin
                playing[i]   = 1'b0;
                play_pos[i]  = '0;
                play_slot[i] = '0;
            end
            errors = 0;
        endfunction

        // Returns the first address an upcoming tick would read that holds no written word.
        function int first_unwritten_read();
            logic [15:0] a;
            for (int v = 0; v < 2; v++) begin
                a = slot_table[play_slot[v]].start + play_pos[v][15:0];
                if (playing[v] && !written[a]) return int'(a);
            end
            return -1;
        endfunction

        function mix_result_t advance_voices();
            mix_result_t     r;
            slmx_pkg::desc_t d;
            logic [15:0]     a;
            int unsigned     nxt_pos;
            r = '0;
            for (int v = 0; v < 2; v++) begin
                if (playing[v]) begin
                    d = slot_table[play_slot[v]];
                    r.active_mask[v] = 1'b1;
                    a = d.start + play_pos[v][15:0];
                    r.mix = r.mix + mem[a];
                    nxt_pos = play_pos[v] + 1;
                    if (nxt_pos >= d.length) begin
                        if (d.loop_en) nxt_pos = 32'(d.loop_pt);
                        else playing[v] = 1'b0;
                    end
                    play_pos[v] = 17'(nxt_pos);
                end
            end
            return r;
        endfunction

        function void apply_command(slmx_pkg::cmd_t op, cmd_fields_t f);
            case (op)
                slmx_pkg::CMD_WRITE: begin
                    mem[f.address]     = f.word_data;
                    written[f.address] = 1'b1;
                end
                slmx_pkg::CMD_LOAD: begin
                    slot_table[f.sample_index].valid   = f.desc_valid;
                    slot_table[f.sample_index].loop_en = f.loop_enable;
                    slot_table[f.sample_index].start   = f.address;
                    slot_table[f.sample_index].length  = f.length;
                    slot_table[f.sample_index].loop_pt = f.loop_point;
                end
                slmx_pkg::CMD_TRIGGER: begin
                    play_pos[f.voice]  = '0;
                    play_slot[f.voice] = f.sample_index;
                    playing[f.voice]   = slot_table[f.sample_index].valid &&
                                         slot_table[f.sample_index].length != 0;
                end
                default: begin
                    pending_mixes.push_back(advance_voices());
                end
            endcase
        endfunction

        function void compare_mix(logic [slmx_pkg::M_TDATA_W-1:0] beat);
            mix_result_t want;
            if (pending_mixes.size() == 0) begin
                $error("Unexpected transaction: mix %h, active_mask %b", beat[15:0], beat[17:16]);
                errors++;
                return;
            end
            want = pending_mixes.pop_front();
            if (beat[15:0] !== want.mix) begin
                $error("mix: expected %h, got %h", want.mix, beat[15:0]);
                errors++;
            end
            if (beat[17:16] !== want.active_mask) begin
                $error("active_mask: expected %b, got %b", want.active_mask, beat[17:16]);
                errors++;
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [slmx_pkg::S_TDATA_W-1:0] s_tdata;
    logic [slmx_pkg::S_TUSER_W-1:0] s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [slmx_pkg::M_TDATA_W-1:0] m_tdata;

    mix_tracker tracker = new();
    int         idle_pct = 0;
    int         stall_left = 0;
    int         cycle_count = 0;

    looping_sample_voice_mixer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.compare_mix(m_tdata);
    end

    function automatic cmd_fields_t rand_fields();
        cmd_fields_t f;
        f.sample_index = 6'($urandom);
        f.voice        = 1'($urandom);
        f.address      = 16'($urandom);
        f.word_data    = 16'($urandom);
        f.length       = 17'($urandom_range(0, 65536));
        f.loop_point   = 16'($urandom);
        f.loop_enable  = 1'($urandom);
        f.desc_valid   = 1'($urandom);
        f.pad          = '0;
        return f;
    endfunction

    task automatic drive_command(slmx_pkg::cmd_t op, cmd_fields_t f);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.apply_command(op, f);
    endtask

    task automatic put_word(logic [15:0] addr, logic [15:0] data);
        cmd_fields_t f;
        f           = rand_fields();
        f.address   = addr;
        f.word_data = data;
        drive_command(slmx_pkg::CMD_WRITE, f);
    endtask

    task automatic put_desc(logic [5:0] slot, logic [15:0] start, logic [16:0] len,
                            logic [15:0] lp, bit lpen, bit usable);
        cmd_fields_t f;
        f              = rand_fields();
        f.sample_index = slot;
        f.address      = start;
        f.length       = len;
        f.loop_point   = lp;
        f.loop_enable  = lpen;
        f.desc_valid   = usable;
        drive_command(slmx_pkg::CMD_LOAD, f);
    endtask

    task automatic start_voice(logic [5:0] slot, bit v);
        cmd_fields_t f;
        f              = rand_fields();
        f.sample_index = slot;
        f.voice        = v;
        drive_command(slmx_pkg::CMD_TRIGGER, f);
    endtask

    // Any word a playing voice is about to read gets written first.
    task automatic tick_once();
        int a;
        a = tracker.first_unwritten_read();
        while (a >= 0) begin
            put_word(16'(a), 16'($urandom));
            a = tracker.first_unwritten_read();
        end
        drive_command(slmx_pkg::CMD_TICK, rand_fields());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_mixes.size() != 0);
    endtask

    task automatic random_command();
        int          pick;
        logic [5:0]  slot;
        logic [16:0] len;
        logic [15:0] lp;
        pick = $urandom_range(0, 99);
        slot = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        if (pick < 10) begin
            drive_command(slmx_pkg::CMD_WRITE, rand_fields());
        end else if (pick < 30) begin
            case ($urandom_range(0, 9))
                0: len = '0;
                1: len = 17'd65536;
                2: len = 17'($urandom_range(0, 65536));
                default: len = 17'($urandom_range(1, 8));
            endcase
            lp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
            put_desc(slot, 16'($urandom), len, lp, 1'($urandom), $urandom_range(0, 6) != 0);
        end else if (pick < 45) begin
            start_voice(slot, 1'($urandom));
        end else begin
            tick_once();
        end
    endtask

    initial begin
        wait (cycle_count >= LIMIT);
        $display("looping_sample_voice_mixer_top verification failed");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_pct = 20;
        put_word(16'h0000, 16'h7FFF);
        put_word(16'h0001, 16'h8000);
        put_word(16'hFFFF, 16'h7FFF);
        tick_once();
        start_voice(6'd5, 1'b0);
        tick_once();
        // Slot 0 starts at the top of memory and wraps; slot 63 plays a single word once.
        put_desc(6'd0, 16'hFFFF, 17'd3, 16'd1, 1'b1, 1'b1);
        put_desc(6'd63, 16'h0000, 17'd1, 16'd0, 1'b0, 1'b1);
        start_voice(6'd0, 1'b0);
        start_voice(6'd63, 1'b1);
        repeat (4) tick_once();
        put_desc(6'd1, 16'h0000, 17'd0, 16'd0, 1'b1, 1'b1);
        start_voice(6'd1, 1'b1);
        tick_once();
        put_desc(6'd2, 16'h0000, 17'd2, 16'hFFFF, 1'b1, 1'b1);
        start_voice(6'd2, 1'b1);
        repeat (3) tick_once();
        // A reload of a playing slot takes effect at once, even with the valid bit clear.
        put_desc(6'd0, 16'h0001, 17'd2, 16'd0, 1'b0, 1'b0);
        tick_once();
        put_desc(6'd3, 16'h8000, 17'd65536, 16'd0, 1'b0, 1'b1);
        start_voice(6'd3, 1'b0);
        tick_once();

        idle_pct = 30;
        repeat (90) random_command();
        wait_drained();
        idle_pct = 0;
        repeat (90) random_command();
        idle_pct = 45;
        repeat (90) random_command();
        idle_pct = 0;
        repeat (90) random_command();

        wait_drained();
        repeat (40) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending_mixes.size() == 0) begin
            $display("looping_sample_voice_mixer_top verification clean");
        end else begin
            $display("looping_sample_voice_mixer_top verification failed");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/slmx_pkg.sv
rtl/core/slmx_alu.sv
rtl/core/slmx_desc_ram.sv
rtl/core/slmx_sample_ram.sv
rtl/core/looping_sample_voice_mixer_top.sv
tb/tb_top.sv
